@@ sv/fpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants of the fixed-partition fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

    // Store geometry
    localparam int NUM_PARTS = 16;
    localparam int SIZE_W    = 16;
    localparam int IDX_W     = 4;                       // partition_index field
    localparam int CNT_W     = $clog2(NUM_PARTS + 1);   // holds 0..NUM_PARTS

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int PIU_W      = 5;                      // partitions_in_use width
    localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POLICY   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PARTS_IN_USE = 1'd1;
    localparam logic [PIU_W-1:0]      PIU_RESET        = 5'd16;

    // Stream words
    localparam int S_DATA_W = 24;   // partition_index, amount, zero pad
    localparam int M_DATA_W = 24;   // placed_partition, left_after, zero pad

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } t_policy;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_step;
        logic commit;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_load;
        logic n_zero;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/fpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpfa_ctrl
// Sequencer: capture, scan over the partitions (allocations only), commit into the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_s_tvalid,
    output logic           o_s_tready,
    input  fpfa_pkg::t_sts i_sts,
    output fpfa_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == ST_IDLE) && r_ready && i_s_tvalid;
        o_cmd.scan_init = (r_state == ST_INIT);
        o_cmd.scan_step = (r_state == ST_SCAN);
        o_cmd.commit    = (r_state == ST_COMMIT) && i_sts.out_free;
    end

    assign o_s_tready = r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (r_ready && i_s_tvalid) begin
                        r_ready <= 1'b0;
                        r_state <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    // request kind is only known once the word is captured
                    r_state <= (i_sts.is_load || i_sts.n_zero) ? ST_COMMIT : ST_SCAN;
                end
                ST_SCAN: begin
                    if (i_sts.scan_last) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    // Scan always ends in commit, never jumps back to idle mid-search
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> (r_state == ST_SCAN || r_state == ST_COMMIT))
        else $error("scan left without commit");

    // No new word taken while an item is in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_ready)
        else $error("ready raised while busy");

    // Commit only issued when the output stage can take it
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit into full output stage");

endmodule

`default_nettype wire

@@ sv/fpfa_dp.sv @@
// ----------------------------------------------------------------------------
// fpfa_dp
// Capacity store, config registers, one-partition-per-cycle fit scan and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // config
    input  wire                                  i_cfg_wr_en,
    input  wire  [fpfa_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [fpfa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // captured request
    input  wire                                  i_req_type,
    input  wire  [fpfa_pkg::IDX_W-1:0]           i_req_idx,
    input  wire  [fpfa_pkg::SIZE_W-1:0]          i_req_amt,
    // control
    input  fpfa_pkg::t_cmd                       i_cmd,
    output fpfa_pkg::t_sts                       o_sts,
    // result
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_granted,
    output logic [fpfa_pkg::IDX_W-1:0]           o_placed,
    output logic [fpfa_pkg::SIZE_W-1:0]          o_left
);

    localparam int NP  = fpfa_pkg::NUM_PARTS;
    localparam int SW  = fpfa_pkg::SIZE_W;
    localparam int IW  = fpfa_pkg::IDX_W;
    localparam int CW  = fpfa_pkg::CNT_W;

    // config
    fpfa_pkg::t_policy          r_policy;
    logic [fpfa_pkg::PIU_W-1:0] r_piu;

    // state
    logic [SW-1:0] r_cap [NP];
    logic [IW-1:0] r_next_ptr;

    // request
    logic          r_type;
    logic [IW-1:0] r_idx;
    logic [SW-1:0] r_amt;

    // scan
    logic [IW-1:0] r_scan;
    logic [CW-1:0] r_cnt;
    logic          r_found;
    logic [IW-1:0] r_best_idx;
    logic [SW-1:0] r_best_val;

    logic [CW-1:0] n_search;
    logic [SW-1:0] cur_cap;
    logic          fits;
    logic          take;
    logic [CW-1:0] scan_inc;
    logic [SW-1:0] left_new;

    // search count, clamped to the store size
    always_comb begin
        if (CW'(r_piu) > CW'(NP)) begin
            n_search = CW'(NP);
        end else begin
            n_search = CW'(r_piu);
        end
    end

    assign cur_cap  = r_cap[r_scan];
    assign fits     = (r_amt <= cur_cap);
    assign take     = fits && (!r_found
                      || (r_policy == fpfa_pkg::POL_BEST  && cur_cap < r_best_val)
                      || (r_policy == fpfa_pkg::POL_WORST && cur_cap > r_best_val));
    assign scan_inc = CW'({1'b0, r_scan}) + CW'(1);
    assign left_new = r_best_val - r_amt;

    always_comb begin
        o_sts           = '0;
        o_sts.is_load   = (r_type == fpfa_pkg::REQ_LOAD);
        o_sts.n_zero    = (n_search == '0);
        o_sts.scan_last = (r_cnt == n_search - CW'(1));
        o_sts.out_free  = !o_out_valid || i_out_ready;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpfa_pkg::POL_FIRST;
            r_piu    <= fpfa_pkg::PIU_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                fpfa_pkg::CFG_FIT_POLICY:   r_policy <= fpfa_pkg::t_policy'(i_cfg_data[1:0]);
                fpfa_pkg::CFG_PARTS_IN_USE: r_piu    <= i_cfg_data[fpfa_pkg::PIU_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_req_type;
            r_idx  <= i_req_idx;
            r_amt  <= i_req_amt;
        end
        if (i_cmd.scan_init) begin
            if (r_policy == fpfa_pkg::POL_NEXT && CW'(r_next_ptr) < n_search) begin
                r_scan <= r_next_ptr;
            end else begin
                r_scan <= '0;
            end
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            // walk in search order, wrapping at the search count
            r_scan <= (scan_inc == n_search) ? '0 : scan_inc[IW-1:0];
            r_cnt  <= r_cnt + CW'(1);
            if (take) begin
                r_found    <= 1'b1;
                r_best_idx <= r_scan;
                r_best_val <= cur_cap;
            end
        end
    end

    // capacity store, next-fit pointer, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NP; i++) begin
                r_cap[i] <= '0;
            end
            r_next_ptr  <= '0;
            o_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_out_valid <= 1'b1;
            o_granted   <= 1'b0;
            o_placed    <= '0;
            o_left      <= '0;
            if (r_type == fpfa_pkg::REQ_LOAD) begin
                if (CW'({1'b0, r_idx}) < CW'(NP)) begin
                    r_cap[r_idx] <= r_amt;
                    r_next_ptr   <= '0;
                    o_granted    <= 1'b1;
                    o_placed     <= r_idx;
                    o_left       <= r_amt;
                end
            end else if (r_found) begin
                r_cap[r_best_idx] <= left_new;
                if (r_policy == fpfa_pkg::POL_NEXT) begin
                    r_next_ptr <= r_best_idx;
                end
                o_granted <= 1'b1;
                o_placed  <= r_best_idx;
                o_left    <= left_new;
            end
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Scan position stays within the searched range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (CW'({1'b0, r_scan}) < n_search && r_cnt < n_search))
        else $error("scan outside search range");

    // Refused result carries no partition and no remainder
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_placed == '0 && o_left == '0))
        else $error("refused result not zeroed");

    // A held candidate always fits the request, so the subtract never wraps
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_type == fpfa_pkg::REQ_ALLOC && r_found) |-> (r_amt <= r_best_val))
        else $error("chosen partition too small");

endmodule

`default_nettype wire

@@ sv/fixed_partition_fit_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Fixed-partition allocator: load capacities, place requests by first, next,
// best or worst fit, report grant, partition and remaining capacity.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                      tuser
//  s (req)   in   [3:0] partition_index, [19:4] amount    req_type
//  m (rsp)   out  [3:0] placed_partition, [19:4] left     granted
//  cfg       in   addr 0 fit_policy[1:0], addr 1 partitions_in_use[4:0]
//
//  Load word: accept, init, commit.
//  Allocate word: accept, init, a scan reading one partition at a time
//  through a single read port, N = min(partitions_in_use, 16) partitions
//  in all (no scan when N is 0), then commit.
//  One word in flight; the next word is accepted while the result waits.
//  A stalled result holds the block in commit until taken.
//  Reset (sync, active low) clears all capacities and the pointer, and sets config to first fit, 16 in use.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // request stream
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [fpfa_pkg::S_DATA_W-1:0]      i_s_tdata,   // partition_index, amount, pad
    input  wire                                i_s_tuser,   // req_type
    // result stream
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [fpfa_pkg::M_DATA_W-1:0]      o_m_tdata,   // placed_partition, left_after, pad
    output logic                               o_m_tuser,   // granted
    // configuration writes
    input  wire                                i_cfg_wr_en,
    input  wire  [fpfa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire  [fpfa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IW = fpfa_pkg::IDX_W;
    localparam int SW = fpfa_pkg::SIZE_W;

    fpfa_pkg::t_cmd cmd;
    fpfa_pkg::t_sts sts;

    logic [IW-1:0] placed;
    logic [SW-1:0] left;

    fpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fpfa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_s_tuser),
        .i_req_idx   (i_s_tdata[IW-1:0]),
        .i_req_amt   (i_s_tdata[IW+SW-1:IW]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_granted   (o_m_tuser),
        .o_placed    (placed),
        .o_left      (left)
    );

    // pack result word, pad bits zero
    assign o_m_tdata = {{(fpfa_pkg::M_DATA_W - IW - SW){1'b0}}, left, placed};

endmodule

`default_nettype wire
